// ===== rtl/phte_pkg.sv =====
// phte_pkg: types, constants and codes shared by the probed hash table engine
// depends on nothing; imported by phte_store and probed_hash_table_engine
`timescale 1ns / 1ps
`default_nettype none

package phte_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SIZE_W      = 11;
    localparam int USE_W       = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    localparam logic [31:0] EMPTY_MARK = 32'hffff_ffff;

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_TABLE_SIZE   = 1'b0;
    localparam logic REG_WRITE_ENABLE = 1'b1;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1024);

    // operation codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_FIND   = 2'd1;
    localparam logic [1:0] MODE_ADD    = 2'd2;
    localparam logic [1:0] MODE_UPDATE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_READ_ONLY = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] home_hash;
        logic [31:0] check_hash_a;
        logic [31:0] check_hash_b;
        logic [15:0] lang_code;
        logic [15:0] platform_code;
        logic [31:0] block_ref;
        logic [9:0]  slot_index;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_block_ref;
        logic [9:0]  hit_slot;
    } t_result;

    typedef struct packed {
        logic [31:0] check_hash_a;
        logic [31:0] check_hash_b;
        logic [15:0] lang_code;
        logic [15:0] platform_code;
        logic [31:0] block_ref;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ISSUE,
        S_COMPARE,
        S_REPORT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/phte_store.sv =====
// phte_store: entry memory, one write port and one registered read port
// depends on phte_pkg
`timescale 1ns / 1ps
`default_nettype none

module phte_store
    import phte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [SLOT_W-1:0] i_wr_addr,
    input  wire t_entry            i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    output t_entry                 o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/probed_hash_table_engine.sv =====
// probed_hash_table_engine: top level, command port, probe sequencer, apb registers
// depends on phte_pkg and phte_store
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each command gives exactly one result, held on
// o_result for one cycle with o_strobe high; the receiver cannot stall it, so it
// must take the result in that cycle. Load and read-only replies pass through
// accept, dispatch and report. Find, add and update probe the entry memory one
// slot at a time, each with an address issue, then a compare of the registered
// read data; the end of the used table is detected in one more issue state. An
// add or update that writes does so in its compare cycle. Probing starts at
// home_hash masked by the clamped table_size - 1, moves up, never wraps, and
// stops at a match, at an empty slot (block_ref all ones) after comparing it,
// or at the end of the used table. The table must be loaded before it is searched.
// Registers: table_size at 0x0 (clamped to the memory depth when used),
// write_enable at 0x4; write only while busy is low and no result is pending.
module probed_hash_table_engine
    import phte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command channel
    input  wire logic              start,
    output logic                   busy,
    input  wire t_item             i_item,
    // result channel
    output logic                   o_strobe,
    output t_result                o_result,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // control state
    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_table_size;
    logic                r_write_enable;

    // datapath registers
    t_item               r_item, n_item;
    t_result             r_result, n_result;
    logic [USE_W-1:0]    r_idx, n_idx;

    // memory interface
    logic                w_wr_en;
    logic [SLOT_W-1:0]   w_wr_addr;
    t_entry              w_wr_data;
    logic                w_rd_en;
    t_entry              w_rd_data;

    // probe helpers
    logic [USE_W-1:0]    w_size_ext;
    logic [USE_W-1:0]    w_used;
    logic [USE_W-1:0]    w_start_idx;
    logic                w_match;
    logic                w_empty;
    logic                w_at_end;
    logic                w_load_ok;
    logic                w_cfg_wr;

    // used size is table_size clamped to the memory depth
    assign w_size_ext  = USE_W'(r_table_size);
    assign w_used      = (w_size_ext > USE_W'(TABLE_DEPTH)) ? USE_W'(TABLE_DEPTH) : w_size_ext;
    assign w_start_idx = (w_used == '0) ? '0 : (USE_W'(i_item.home_hash) & (w_used - 1'b1));

    // the shared compare unit, fed by the registered read data
    assign w_match = (w_rd_data.check_hash_a  == r_item.check_hash_a)
                  && (w_rd_data.check_hash_b  == r_item.check_hash_b)
                  && (w_rd_data.lang_code     == r_item.lang_code)
                  && (w_rd_data.platform_code == r_item.platform_code);
    assign w_empty   = (w_rd_data.block_ref == EMPTY_MARK);
    assign w_at_end  = (r_idx >= w_used);
    assign w_load_ok = (32'(r_item.slot_index) < 32'(TABLE_DEPTH));

    // load, add and update all write the command's key with its block_ref:
    // an update only writes on a key match, so the stored key is unchanged
    assign w_wr_data = '{check_hash_a:  r_item.check_hash_a,
                         check_hash_b:  r_item.check_hash_b,
                         lang_code:     r_item.lang_code,
                         platform_code: r_item.platform_code,
                         block_ref:     r_item.block_ref};

    phte_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[SLOT_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_item.mode == MODE_LOAD) begin
                    n_state = S_REPORT;
                end else if ((r_item.mode == MODE_ADD || r_item.mode == MODE_UPDATE)
                             && !r_write_enable) begin
                    n_state = S_REPORT;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = w_at_end ? S_REPORT : S_COMPARE;
            end
            S_COMPARE: begin
                n_state = (w_match || w_empty) ? S_REPORT : S_ISSUE;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_item    = r_item;
        n_result  = r_result;
        n_idx     = r_idx;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[SLOT_W-1:0];
        w_rd_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_idx  = w_start_idx;
                end
            end
            S_DISPATCH: begin
                n_result = '{status: ST_NOT_FOUND, found_block_ref: '0, hit_slot: '0};
                if (r_item.mode == MODE_LOAD) begin
                    // load ignores write_enable and writes its slot directly
                    w_wr_addr = SLOT_W'(r_item.slot_index);
                    if (w_load_ok) begin
                        w_wr_en  = 1'b1;
                        n_result = '{status: ST_OK, found_block_ref: '0,
                                     hit_slot: r_item.slot_index};
                    end
                end else if ((r_item.mode == MODE_ADD || r_item.mode == MODE_UPDATE)
                             && !r_write_enable) begin
                    n_result.status = ST_READ_ONLY;
                end
            end
            S_ISSUE: begin
                if (w_at_end) begin
                    // ran off the end of the used table
                    n_result = '{status: (r_item.mode == MODE_ADD) ? ST_FULL : ST_NOT_FOUND,
                                 found_block_ref: '0, hit_slot: '0};
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            S_COMPARE: begin
                if (w_match) begin
                    case (r_item.mode)
                        MODE_FIND: begin
                            n_result = '{status: ST_OK, found_block_ref: w_rd_data.block_ref,
                                         hit_slot: 10'(r_idx)};
                        end
                        MODE_ADD: begin
                            n_result = '{status: ST_DUPLICATE, found_block_ref: '0,
                                         hit_slot: '0};
                        end
                        MODE_UPDATE: begin
                            w_wr_en  = 1'b1;
                            n_result = '{status: ST_OK, found_block_ref: '0,
                                         hit_slot: 10'(r_idx)};
                        end
                        default: begin
                            n_result = '{status: ST_NOT_FOUND, found_block_ref: '0,
                                         hit_slot: '0};
                        end
                    endcase
                end else if (w_empty) begin
                    // empty slot ends the probe; add claims it
                    if (r_item.mode == MODE_ADD) begin
                        w_wr_en  = 1'b1;
                        n_result = '{status: ST_OK, found_block_ref: '0,
                                     hit_slot: 10'(r_idx)};
                    end else begin
                        n_result = '{status: ST_NOT_FOUND, found_block_ref: '0,
                                     hit_slot: '0};
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_REPORT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_table_size   <= TABLE_SIZE_RESET;
            r_write_enable <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_TABLE_SIZE: begin
                        r_table_size <= pwdata[SIZE_W-1:0];
                    end
                    REG_WRITE_ENABLE: begin
                        r_write_enable <= pwdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
        r_idx    <= n_idx;
    end

    // apb access: zero wait states
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_TABLE_SIZE:   prdata = 32'(r_table_size);
            REG_WRITE_ENABLE: prdata = 32'(r_write_enable);
            default:          prdata = '0;
        endcase
    end

    // command and result handshakes
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_REPORT);
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== tb/sv/probed_hash_table_engine_tb.sv =====
// probed_hash_table_engine_tb: self-checking bench for the probed hash table engine
// holds a table scoreboard class, command and apb drivers and the stimulus sequence
// depends on phte_pkg and the probed_hash_table_engine rtl
`timescale 1ns / 1ps

module probed_hash_table_engine_tb;
    import phte_pkg::*;

    // worst case: ~1500 commands each walking the whole table behind the longest
    // sender gap, taken several times over
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int KEY_POOL_N  = 8;

    // how a probe walk ended
    typedef enum logic [1:0] {
        PROBE_HIT,
        PROBE_EMPTY,
        PROBE_END,
        PROBE_UNLOADED
    } t_probe_end;

    // table scoreboard: private copy of the entry store and registers,
    // expected replies queued in command order
    class hash_table_scoreboard;
        t_entry      slot_mem [TABLE_DEPTH];
        bit          slot_loaded [TABLE_DEPTH];
        int unsigned size_reg = TABLE_SIZE_RESET;
        bit          wr_en = 1'b0;
        t_result     expected_replies [$];
        int          error_count = 0;

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_TABLE_SIZE) begin
                size_reg = val[SIZE_W-1:0];
            end else begin
                wr_en = val[0];
            end
        endfunction

        function int unsigned used_slots();
            return (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
        endfunction

        function void store_entry(int unsigned slot, t_item it);
            slot_mem[slot] = '{check_hash_a: it.check_hash_a, check_hash_b: it.check_hash_b,
                               lang_code: it.lang_code, platform_code: it.platform_code,
                               block_ref: it.block_ref};
            slot_loaded[slot] = 1'b1;
        endfunction

        // compare before the empty check, so a matching empty slot is a hit
        function t_probe_end walk_chain(t_item it, output int unsigned slot);
            int unsigned n;
            int unsigned first;
            n = used_slots();
            first = (n == 0) ? 0 : (it.home_hash & (n - 1));
            slot = 0;
            for (int unsigned k = first; k < n; k++) begin
                slot = k;
                if (!slot_loaded[k]) return PROBE_UNLOADED;
                if (slot_mem[k].check_hash_a == it.check_hash_a &&
                    slot_mem[k].check_hash_b == it.check_hash_b &&
                    slot_mem[k].lang_code == it.lang_code &&
                    slot_mem[k].platform_code == it.platform_code) return PROBE_HIT;
                if (slot_mem[k].block_ref == EMPTY_MARK) return PROBE_EMPTY;
            end
            slot = 0;
            return PROBE_END;
        endfunction

        // first never-written slot the command would read, or -1
        function int unloaded_on_path(t_item it);
            int unsigned slot;
            if (it.mode == MODE_LOAD || (it.mode != MODE_FIND && !wr_en)) return -1;
            if (walk_chain(it, slot) == PROBE_UNLOADED) return int'(slot);
            return -1;
        endfunction

        // work out the reply of an accepted command and apply its table write
        function void note_command(t_item it);
            t_result     want;
            int unsigned slot;
            t_probe_end  stop;
            want = '0;
            if (it.mode == MODE_LOAD) begin
                store_entry(it.slot_index, it);
                want.hit_slot = it.slot_index;
            end else if (it.mode != MODE_FIND && !wr_en) begin
                want.status = ST_READ_ONLY;
            end else begin
                stop = walk_chain(it, slot);
                case (it.mode)
                    MODE_FIND: begin
                        if (stop == PROBE_HIT) begin
                            want.found_block_ref = slot_mem[slot].block_ref;
                            want.hit_slot = SLOT_W'(slot);
                        end else begin
                            want.status = ST_NOT_FOUND;
                        end
                    end
                    MODE_ADD: begin
                        if (stop == PROBE_HIT) begin
                            want.status = ST_DUPLICATE;
                        end else if (stop == PROBE_EMPTY) begin
                            store_entry(slot, it);
                            want.hit_slot = SLOT_W'(slot);
                        end else begin
                            want.status = ST_FULL;
                        end
                    end
                    default: begin
                        if (stop == PROBE_HIT) begin
                            slot_mem[slot].block_ref = it.block_ref;
                            want.hit_slot = SLOT_W'(slot);
                        end else begin
                            want.status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            expected_replies.push_back(want);
        endfunction

        function void check_reply(t_result got);
            t_result want;
            if (expected_replies.size() == 0) begin
                $error("reply with no command outstanding: status %0d hit_slot %0d",
                       got.status, got.hit_slot);
                error_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                error_count++;
            end
            if (got.found_block_ref !== want.found_block_ref) begin
                $error("found_block_ref expected %h got %h",
                       want.found_block_ref, got.found_block_ref);
                error_count++;
            end
            if (got.hit_slot !== want.hit_slot) begin
                $error("hit_slot expected %0d got %0d", want.hit_slot, got.hit_slot);
                error_count++;
            end
        endfunction
    endclass

    // dut signals; the inputs are all known from time zero
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_item             i_item  = '0;
    logic              o_strobe;
    t_result           o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    hash_table_scoreboard sb;
    t_entry               key_pool [KEY_POOL_N];
    int                   cycle_count = 0;

    probed_hash_table_engine u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: the strobe lasts one cycle and cannot be stalled,
    // so every strobed cycle is one result transfer
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            sb.check_reply(o_result);
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("probed_hash_table_engine test failed");
        $finish;
    end

    function automatic t_entry random_key();
        t_entry k;
        k.check_hash_a  = $urandom();
        k.check_hash_b  = $urandom();
        k.lang_code     = 16'($urandom());
        k.platform_code = 16'($urandom());
        k.block_ref     = '0;
        return k;
    endfunction

    function automatic t_item make_cmd(logic [1:0] mode, logic [31:0] hash, t_entry key,
                                       logic [31:0] blk, logic [SLOT_W-1:0] slot);
        t_item it;
        it.mode          = mode;
        it.home_hash     = hash;
        it.check_hash_a  = key.check_hash_a;
        it.check_hash_b  = key.check_hash_b;
        it.lang_code     = key.lang_code;
        it.platform_code = key.platform_code;
        it.block_ref     = blk;
        it.slot_index    = slot;
        return it;
    endfunction

    // random command; keys mostly come from a small pool so hits, duplicates
    // and full chains are common. a probe that would read a never-written
    // slot is redrawn, and failing that turned into a load of that slot
    function automatic t_item draw_command();
        t_item       it;
        t_entry      key;
        int          pick;
        int          miss;
        int unsigned n;
        pick = $urandom_range(0, 99);
        key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, KEY_POOL_N - 1)]
                                           : random_key();
        n    = sb.used_slots();
        it   = make_cmd(MODE_FIND, $urandom(), key,
                        ($urandom_range(0, 9) < 3) ? EMPTY_MARK : $urandom(),
                        SLOT_W'($urandom()));
        if (pick < 25) begin
            it.mode = MODE_LOAD;
        end else if (pick < 55) begin
            it.mode = MODE_FIND;
        end else if (pick < 80) begin
            it.mode = MODE_ADD;
        end else begin
            it.mode = MODE_UPDATE;
        end
        if (n > 0 && $urandom_range(0, 9) < 6) begin
            it.slot_index = SLOT_W'($urandom_range(0, n - 1));
        end
        for (int k = 0; k < 8 && sb.unloaded_on_path(it) >= 0; k++) begin
            it.home_hash = $urandom();
        end
        miss = sb.unloaded_on_path(it);
        if (miss >= 0) begin
            it.mode       = MODE_LOAD;
            it.slot_index = SLOT_W'(miss);
        end
        return it;
    endfunction

    // drop start and let the given number of cycles pass
    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // one command transfer: start stays high until an edge sees busy low
    task automatic issue(t_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(it);
    endtask

    // sender pauses until every reply is back and the engine is idle;
    // checked on the falling edge, away from the result monitor
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.expected_replies.size() != 0 || busy !== 1'b0);
        @(posedge i_clk);
    endtask

    // apb write; psel stays up so a following write can go straight to setup
    task automatic apb_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    task automatic set_regs(logic [31:0] size_val, logic we_val);
        wait_drained();
        apb_write(REG_TABLE_SIZE, size_val);
        apb_write(REG_WRITE_ENABLE, {31'd0, we_val});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_cmd(logic [1:0] mode, logic [31:0] hash, t_entry key,
                                logic [31:0] blk, logic [SLOT_W-1:0] slot);
        hold_off($urandom_range(0, 16));
        issue(make_cmd(mode, hash, key, blk, slot));
    endtask

    task automatic run_phase(logic [31:0] size_val, logic we_val, int count);
        bit no_gaps;
        set_regs(size_val, we_val);
        // some phases run back to back with no sender gaps at all
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if ($urandom_range(0, 59) == 0) wait_drained();
            hold_off(no_gaps ? 0 : $urandom_range(0, 16));
            issue(draw_command());
        end
    endtask

    initial begin
        t_entry kz, ko, ka, kb, kc;
        sb = new;
        for (int k = 0; k < KEY_POOL_N; k++) key_pool[k] = random_key();
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[1].block_ref = '0;
        kz = key_pool[0];
        ko = key_pool[1];
        ka = key_pool[2];
        kb = key_pool[3];
        kc = key_pool[4];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: full table, writes disabled
        directed_cmd(MODE_ADD, 32'hffff_ffff, ko, EMPTY_MARK, '1);   // read-only
        directed_cmd(MODE_UPDATE, 32'h0, kz, 32'h0, '0);              // read-only
        directed_cmd(MODE_LOAD, 32'h0, ko, 32'h0, '1);                // top slot
        directed_cmd(MODE_LOAD, 32'h0, kz, 32'h0, '0);
        directed_cmd(MODE_LOAD, 32'h0, ka, EMPTY_MARK, SLOT_W'(1));
        directed_cmd(MODE_LOAD, 32'h0, kb, EMPTY_MARK, SLOT_W'(2));
        directed_cmd(MODE_FIND, 32'hffff_ffff, ko, 32'h0, '0);       // hit at top slot
        directed_cmd(MODE_FIND, 32'hffff_fc00, kz, 32'h0, '0);       // hit at slot 0
        directed_cmd(MODE_FIND, 32'h0, kc, 32'h0, '0);                // stops at empty
        directed_cmd(MODE_FIND, 32'h0000_03ff, kc, 32'h0, '0);       // runs off the end

        set_regs(32'd1024, 1'b1);
        directed_cmd(MODE_ADD, 32'h0000_03ff, kc, 32'h1234_5678, '0); // table full
        directed_cmd(MODE_ADD, 32'h0, kc, 32'h1234_5678, '0);         // fills slot 1
        directed_cmd(MODE_ADD, 32'h0, kc, 32'h0, '0);                 // duplicate
        directed_cmd(MODE_UPDATE, 32'h0, kc, EMPTY_MARK, '0);         // now keyed but empty
        directed_cmd(MODE_FIND, 32'h0, kc, 32'h0, '0);                // matching empty slot
        directed_cmd(MODE_ADD, 32'h0, kc, 32'h0, '0);                 // duplicate of empty
        directed_cmd(MODE_UPDATE, 32'h0, ka, 32'h0, '0);              // not found

        // zero size probes nothing
        set_regs(32'd0, 1'b1);
        directed_cmd(MODE_FIND, 32'h0, kz, 32'h0, '0);
        directed_cmd(MODE_ADD, 32'h0, ka, 32'h0, '0);
        directed_cmd(MODE_UPDATE, 32'h0, kz, 32'h0, '0);

        // oversized size is clamped to the memory depth
        set_regs(32'd2047, 1'b1);
        directed_cmd(MODE_FIND, 32'hffff_ffff, ko, 32'h0, '0);

        // size that is not a power of two
        set_regs(32'd3, 1'b1);
        directed_cmd(MODE_FIND, 32'h2, kb, 32'h0, '0);
        directed_cmd(MODE_ADD, 32'h1, ka, 32'hffff_0000, '0);

        // single-slot table
        set_regs(32'd1, 1'b1);
        directed_cmd(MODE_FIND, 32'hffff_ffff, kz, 32'h0, '0);
        directed_cmd(MODE_ADD, 32'h0, kb, 32'h0, '0);

        // random phases across register settings, extremes included
        run_phase(32'd16, 1'b1, 150);
        run_phase(32'd1024, 1'b1, 200);
        run_phase(32'd4, 1'b1, 100);
        run_phase(32'd64, 1'b0, 80);
        run_phase(32'd64, 1'b1, 150);
        run_phase(32'd1, 1'b1, 40);
        run_phase(32'd2, 1'b1, 60);
        run_phase(32'd0, 1'b1, 30);
        run_phase(32'd12, 1'b1, 120);
        run_phase(32'd2047, 1'b1, 150);
        run_phase(32'd8, 1'b1, 120);
        run_phase(32'd32, 1'b1, 150);
        run_phase(32'd1024, 1'b0, 100);

        wait_drained();
        // then wait on to catch any stray reply
        repeat (20) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("probed_hash_table_engine test passed");
        end else begin
            $display("probed_hash_table_engine test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phte_pkg.sv
rtl/phte_store.sv
rtl/probed_hash_table_engine.sv
tb/sv/probed_hash_table_engine_tb.sv
